@@ rtl/rtc_cal_pkg.sv @@
package rtc_cal_pkg;

  // field widths
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned WdayW  = 3;

  // calendar limits
  localparam logic [SecW-1:0]  SecMax   = SecW'(59);
  localparam logic [MinW-1:0]  MinMax   = MinW'(59);
  localparam logic [HourW-1:0] HourMax  = HourW'(23);
  localparam logic [MonW-1:0]  MonMax   = MonW'(12);
  localparam logic [YearW-1:0] YearMin  = YearW'(1901);
  localparam logic [YearW-1:0] YearMax  = YearW'(2099);
  localparam logic [WdayW-1:0] WdayMax  = WdayW'(6);

  // reset date 2000-01-01 is a saturday
  localparam logic [DayW-1:0]  DayRst   = DayW'(1);
  localparam logic [MonW-1:0]  MonRst   = MonW'(1);
  localparam logic [YearW-1:0] YearRst  = YearW'(2000);
  localparam logic [WdayW-1:0] WdayRst  = WdayW'(6);

  // 1901-01-01, the date after the year wrap, is a tuesday
  localparam logic [WdayW-1:0] WdayYearMin = WdayW'(2);

  // day-number offset so that the weekday comes out with sunday as zero
  localparam int unsigned DayNumW    = 20;
  localparam int unsigned DayRelW    = 18;
  localparam logic [DayNumW-1:0] DayNumBase = DayNumW'(621049);

  typedef enum logic {
    ReqTick = 1'b0,
    ReqSet  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [SecW-1:0]  second_now;
    logic [MinW-1:0]  minute_now;
    logic [HourW-1:0] hour_now;
    logic [DayW-1:0]  day_now;
    logic [MonW-1:0]  month_now;
    logic [YearW-1:0] year_now;
    logic [WdayW-1:0] weekday_now;
    logic             set_rejected;
  } rsp_t;

  // only valid for 1901..2099, where the one century year (2000) is a leap year
  function automatic logic is_leap(logic [YearW-1:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(30);
      default:                   len = DayW'(31);
    endcase
    return len;
  endfunction

  // floor(153 * g / 5), g = month + 13 for jan/feb, else month + 1
  function automatic logic [8:0] month_term(logic [MonW-1:0] m);
    logic [8:0] t;
    unique case (m)
      4'd1:    t = 9'(153 * 14 / 5);
      4'd2:    t = 9'(153 * 15 / 5);
      4'd3:    t = 9'(153 * 4 / 5);
      4'd4:    t = 9'(153 * 5 / 5);
      4'd5:    t = 9'(153 * 6 / 5);
      4'd6:    t = 9'(153 * 7 / 5);
      4'd7:    t = 9'(153 * 8 / 5);
      4'd8:    t = 9'(153 * 9 / 5);
      4'd9:    t = 9'(153 * 10 / 5);
      4'd10:   t = 9'(153 * 11 / 5);
      4'd11:   t = 9'(153 * 12 / 5);
      default: t = 9'(153 * 13 / 5);
    endcase
    return t;
  endfunction

  // 8 = 1 mod 7, so fold 3-bit digits then one compare and subtract
  function automatic logic [WdayW-1:0] mod7(logic [DayRelW-1:0] x);
    logic [5:0] s;
    logic [3:0] t;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
      + 6'(x[14:12]) + 6'(x[17:15]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    return (t >= 4'd7) ? WdayW'(t - 4'd7) : WdayW'(t);
  endfunction

  // day-number formula, year 1901..2099 and month 1..12
  function automatic logic [WdayW-1:0] weekday_of(logic [YearW-1:0] y,
                                                   logic [MonW-1:0] m,
                                                   logic [DayW-1:0] d);
    logic [YearW-1:0] f;
    logic [21:0]      prod;
    logic [DayNumW-1:0] n;
    logic [DayNumW-1:0] rel;
    f    = (m <= 4'd2) ? (y - YearW'(1)) : y;
    prod = 22'(f) * 22'(1461);
    n    = prod[21:2] + DayNumW'(month_term(m)) + DayNumW'(d);
    rel  = n - DayNumBase;
    return mod7(rel[DayRelW-1:0]);
  endfunction

endpackage

@@ rtl/rtc_cal_req_if.sv @@
interface rtc_cal_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [rtc_cal_pkg::SecW-1:0]       set_second;
  logic [rtc_cal_pkg::MinW-1:0]       set_minute;
  logic [rtc_cal_pkg::HourW-1:0]      set_hour;
  logic [rtc_cal_pkg::DayW-1:0]       set_day;
  logic [rtc_cal_pkg::MonW-1:0]       set_month;
  logic [rtc_cal_pkg::YearW-1:0]      set_year;

  modport source (
    output valid, req_type, set_second, set_minute, set_hour, set_day, set_month, set_year,
    input  ready
  );
  modport sink (
    input  valid, req_type, set_second, set_minute, set_hour, set_day, set_month, set_year,
    output ready
  );
endinterface

@@ rtl/rtc_cal_rsp_if.sv @@
interface rtc_cal_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [rtc_cal_pkg::SecW-1:0]       second_now;
  logic [rtc_cal_pkg::MinW-1:0]       minute_now;
  logic [rtc_cal_pkg::HourW-1:0]      hour_now;
  logic [rtc_cal_pkg::DayW-1:0]       day_now;
  logic [rtc_cal_pkg::MonW-1:0]       month_now;
  logic [rtc_cal_pkg::YearW-1:0]      year_now;
  logic [rtc_cal_pkg::WdayW-1:0]      weekday_now;
  logic                               set_rejected;

  modport source (
    output valid, second_now, minute_now, hour_now, day_now, month_now, year_now,
           weekday_now, set_rejected,
    input  ready
  );
  modport sink (
    input  valid, second_now, minute_now, hour_now, day_now, month_now, year_now,
           weekday_now, set_rejected,
    output ready
  );
endinterface

@@ rtl/rtc_calendar_tick_top.sv @@
// real-time clock and gregorian calendar, 1901-01-01 .. 2099-12-31. every request
// transfer is either a one-second tick or a set of the full time and date, and each
// produces exactly one response transfer with the time, date and weekday after it
// (0 = sunday). a tick rolls seconds, minutes and hours and at 00:00:00 advances the
// date; after 2099-12-31 the date wraps to 1901-01-01. a set that is out of range
// (including a day beyond the month length) changes nothing and returns
// set_rejected = 1. after reset the clock reads 2000-01-01 00:00:00, saturday.
// one request is taken every cycle while the buffer tail is empty: the clock registers
// update at the request transfer and the response is registered in a two-entry output buffer,
// so one more request is still taken while the response side stalls.
// the critical path is the set path: one constant multiply (year * 1461) and the
// add / mod-7 fold of the weekday formula.
module rtc_calendar_tick_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  rtc_cal_req_if.sink    req_i,
  rtc_cal_rsp_if.source  rsp_o
);

  // clock and calendar state
  logic [rtc_cal_pkg::SecW-1:0]  sec_q,  sec_d;
  logic [rtc_cal_pkg::MinW-1:0]  min_q,  min_d;
  logic [rtc_cal_pkg::HourW-1:0] hour_q, hour_d;
  logic [rtc_cal_pkg::DayW-1:0]  day_q,  day_d;
  logic [rtc_cal_pkg::MonW-1:0]  mon_q,  mon_d;
  logic [rtc_cal_pkg::YearW-1:0] year_q, year_d;
  logic [rtc_cal_pkg::WdayW-1:0] wday_q, wday_d;

  // output buffer: head drives the response, tail catches one more while stalled
  rtc_cal_pkg::rsp_t head_q, head_d, tail_q, tail_d, rsp_new;
  logic              head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;

  logic push, pop;
  logic is_set;
  logic set_ok;
  logic sec_wrap, min_wrap, hour_wrap, midnight;
  logic month_end, year_end, range_end;

  assign push   = req_i.valid & req_i.ready;
  assign pop    = head_vld_q & rsp_o.ready;
  assign is_set = (req_i.req_type == rtc_cal_pkg::ReqSet);

  // range checks of a set, day checked against the length of the requested month
  assign set_ok = (req_i.set_second <= rtc_cal_pkg::SecMax)
               && (req_i.set_minute <= rtc_cal_pkg::MinMax)
               && (req_i.set_hour   <= rtc_cal_pkg::HourMax)
               && (req_i.set_month  >= rtc_cal_pkg::MonW'(1))
               && (req_i.set_month  <= rtc_cal_pkg::MonMax)
               && (req_i.set_year   >= rtc_cal_pkg::YearMin)
               && (req_i.set_year   <= rtc_cal_pkg::YearMax)
               && (req_i.set_day    >= rtc_cal_pkg::DayW'(1))
               && (req_i.set_day    <= rtc_cal_pkg::month_len(req_i.set_month,
                                          rtc_cal_pkg::is_leap(req_i.set_year)));

  // tick carries
  assign sec_wrap  = (sec_q  == rtc_cal_pkg::SecMax);
  assign min_wrap  = (min_q  == rtc_cal_pkg::MinMax);
  assign hour_wrap = (hour_q == rtc_cal_pkg::HourMax);
  assign midnight  = sec_wrap & min_wrap & hour_wrap;

  // date carries, only used when the tick lands on midnight
  assign month_end = (day_q >= rtc_cal_pkg::month_len(mon_q, rtc_cal_pkg::is_leap(year_q)));
  assign year_end  = month_end & (mon_q >= rtc_cal_pkg::MonMax);
  assign range_end = year_end & (year_q >= rtc_cal_pkg::YearMax);

  always_comb begin
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    wday_d = wday_q;
    if (is_set) begin
      if (set_ok) begin
        sec_d  = req_i.set_second;
        min_d  = req_i.set_minute;
        hour_d = req_i.set_hour;
        day_d  = req_i.set_day;
        mon_d  = req_i.set_month;
        year_d = req_i.set_year;
        wday_d = rtc_cal_pkg::weekday_of(req_i.set_year, req_i.set_month, req_i.set_day);
      end
    end else begin
      sec_d = sec_wrap ? '0 : sec_q + rtc_cal_pkg::SecW'(1);
      if (sec_wrap) begin
        min_d = min_wrap ? '0 : min_q + rtc_cal_pkg::MinW'(1);
      end
      if (sec_wrap && min_wrap) begin
        hour_d = hour_wrap ? '0 : hour_q + rtc_cal_pkg::HourW'(1);
      end
      if (midnight) begin
        // consecutive days differ by one in the day number, so the weekday steps, but the wrap to 1901 reloads it
        if (!month_end) begin
          day_d = day_q + rtc_cal_pkg::DayW'(1);
        end else if (year_end) begin
          day_d  = rtc_cal_pkg::DayW'(1);
          mon_d  = rtc_cal_pkg::MonW'(1);
          year_d = range_end ? rtc_cal_pkg::YearMin : year_q + rtc_cal_pkg::YearW'(1);
        end else begin
          day_d = rtc_cal_pkg::DayW'(1);
          mon_d = mon_q + rtc_cal_pkg::MonW'(1);
        end
        if (range_end) begin
          wday_d = rtc_cal_pkg::WdayYearMin;
        end else begin
          wday_d = (wday_q >= rtc_cal_pkg::WdayMax) ? '0
                                                    : wday_q + rtc_cal_pkg::WdayW'(1);
        end
      end
    end
  end

  always_comb begin
    rsp_new.second_now   = sec_d;
    rsp_new.minute_now   = min_d;
    rsp_new.hour_now     = hour_d;
    rsp_new.day_now      = day_d;
    rsp_new.month_now    = mon_d;
    rsp_new.year_now     = year_d;
    rsp_new.weekday_now  = wday_d;
    rsp_new.set_rejected = is_set & ~set_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      day_q  <= rtc_cal_pkg::DayRst;
      mon_q  <= rtc_cal_pkg::MonRst;
      year_q <= rtc_cal_pkg::YearRst;
      wday_q <= rtc_cal_pkg::WdayRst;
    end else if (push) begin
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      wday_q <= wday_d;
    end
  end

  // output buffer; a push only happens with the tail empty
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop) begin
      head_d     = tail_q;
      head_vld_d = tail_vld_q;
      tail_vld_d = 1'b0;
    end
    if (push) begin
      if (!head_vld_d) begin
        head_d     = rsp_new;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = rsp_new;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign req_i.ready = ~tail_vld_q;

  assign rsp_o.valid        = head_vld_q;
  assign rsp_o.second_now   = head_q.second_now;
  assign rsp_o.minute_now   = head_q.minute_now;
  assign rsp_o.hour_now     = head_q.hour_now;
  assign rsp_o.day_now      = head_q.day_now;
  assign rsp_o.month_now    = head_q.month_now;
  assign rsp_o.year_now     = head_q.year_now;
  assign rsp_o.weekday_now  = head_q.weekday_now;
  assign rsp_o.set_rejected = head_q.set_rejected;

  // tail never holds a response without the head
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_vld_q |-> head_vld_q)
    else $error("output buffer tail valid with empty head");

  // a rejected set leaves the clock and calendar untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && is_set && !set_ok) |=> ($stable(sec_q) && $stable(min_q) && $stable(hour_q)
      && $stable(day_q) && $stable(mon_q) && $stable(year_q) && $stable(wday_q)))
    else $error("rejected set changed the clock state");

  // a tick before midnight never touches the date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !is_set && !midnight) |=> ($stable(day_q) && $stable(mon_q)
      && $stable(year_q) && $stable(wday_q)))
    else $error("date changed on a tick before midnight");

  // at midnight the day steps by one or restarts at the first of the month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !is_set && midnight) |=> ((day_q == rtc_cal_pkg::DayW'(1))
      || (day_q == $past(day_q) + rtc_cal_pkg::DayW'(1))))
    else $error("day did not advance at midnight");

  // after an accepted request the output holds a valid response on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> head_vld_q)
    else $error("response missing after request transfer");

endmodule
